// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Both assume a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/eeg_fd_pkg.sv =====
// ----------------------------------------------------------------------------
// eeg_fd_pkg
// Types and fixed frame layout constants for the EEG frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eeg_fd_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAB;
  localparam logic [7:0] SYNC_SECOND = 8'hCD;

  localparam int SUM_FIRST  = 2;   // first byte covered by the checksum
  localparam int SUM_LAST   = 33;  // last byte covered by the checksum
  localparam int SUM_POS    = 34;  // checksum byte
  localparam int TIME_POS   = 3;   // board timestamp, 4 bytes big-endian
  localparam int SAMPLE_POS = 10;  // first sample byte
  localparam int CHANNELS   = 8;
  localparam int SAMPLE_W   = 24;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic [31:0]                        board_time;
    logic [CHANNELS-1:0][SAMPLE_W-1:0]  samples;
  } frame_t;

  // Front to queue: one decoded frame per transfer.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } push_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== src/eeg_frame_deframer.sv =====
// A good frame goes from its last byte into a queue entry, then the output register.
// Throughput: one byte per cycle; the input stalls only when the two-entry
//   queue and the output register are all held by a stalled output side.
// Reset (rst, synchronous): empties the window, queue and output register;
//   no start-up pass is needed, bytes are taken from the first cycle after.
// ----------------------------------------------------------------------------
// eeg_frame_deframer
// Sync-word frame deframer with a modulo-256 sum check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eeg_frame_deframer
  import eeg_fd_pkg::*;
#(
  parameter int FRAME_BYTES = 37   // window length, 35 to 64
) (
  input  logic               clk,
  input  logic               rst,
  // byte input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  // frame result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        board_time,
  output logic signed [23:0] sample_0,
  output logic signed [23:0] sample_1,
  output logic signed [23:0] sample_2,
  output logic signed [23:0] sample_3,
  output logic signed [23:0] sample_4,
  output logic signed [23:0] sample_5,
  output logic signed [23:0] sample_6,
  output logic signed [23:0] sample_7
);

  push_t   push;
  q_stat_t q_stat;
  frame_t  head;
  frame_t  result;
  logic    pop;

  // Front: the byte window shifts on every transfer. A running sum over the
  // checksum span is updated by one add and one subtract per byte, so the
  // check of a full window (two sync bytes plus sum compare) fits in the
  // same cycle as the byte that completes it. A good frame is pushed into
  // the queue with its fields already picked out; the window then restarts.
  eeg_fd_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_stat   (q_stat),
    .push     (push)
  );

  // Queue: decouples the byte side from a stalled result consumer.
  eeg_fd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Back: registered result transfer.
  eeg_fd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign board_time = result.board_time;
  assign sample_0   = $signed(result.samples[0]);
  assign sample_1   = $signed(result.samples[1]);
  assign sample_2   = $signed(result.samples[2]);
  assign sample_3   = $signed(result.samples[3]);
  assign sample_4   = $signed(result.samples[4]);
  assign sample_5   = $signed(result.samples[5]);
  assign sample_6   = $signed(result.samples[6]);
  assign sample_7   = $signed(result.samples[7]);

endmodule

`default_nettype wire

// ===== src/eeg_fd_front.sv =====
// ----------------------------------------------------------------------------
// eeg_fd_front
// Byte window, sliding checksum and frame check; pushes good frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eeg_fd_front
  import eeg_fd_pkg::*;
#(
  parameter int FRAME_BYTES = 37
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic [7:0] rx_byte,
  input  q_stat_t q_stat,
  output push_t   push
);

  localparam int FILL_W = $clog2(FRAME_BYTES);

  // Newest byte always at the top; when the window is full it sits at 0..N-1.
  byte_t             window      [FRAME_BYTES];
  byte_t             window_next [FRAME_BYTES];
  byte_t             win_sum;
  byte_t             win_sum_next;
  logic [FILL_W-1:0] fill;
  logic              accept;
  logic              full_now;
  logic              frame_ok;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign full_now = (fill == FILL_W'(FRAME_BYTES - 1));

  always_comb begin
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      window_next[i] = window[i + 1];
    end
    window_next[FRAME_BYTES - 1] = rx_byte;
  end

  // Sum of positions 2..33 slides by one byte per shift.
  assign win_sum_next = win_sum - window[SUM_FIRST] + window_next[SUM_LAST];

  assign frame_ok = (window_next[0] == SYNC_FIRST) && (window_next[1] == SYNC_SECOND) &&
                    (win_sum_next == window_next[SUM_POS]);

  always_comb begin
    push.valid            = accept && full_now && frame_ok;
    push.frame.board_time = {window_next[TIME_POS], window_next[TIME_POS + 1],
                             window_next[TIME_POS + 2], window_next[TIME_POS + 3]};
    for (int c = 0; c < CHANNELS; c++) begin
      push.frame.samples[c] = {window_next[SAMPLE_POS + 3 * c],
                               window_next[SAMPLE_POS + 3 * c + 1],
                               window_next[SAMPLE_POS + 3 * c + 2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      win_sum <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      win_sum <= win_sum_next;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        window[i] <= window_next[i];
      end
      if (full_now) begin
        // good frame empties the window; a bad one drops the oldest byte
        if (frame_ok) begin
          fill <= '0;
        end
      end else begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/eeg_fd_queue.sv =====
// ----------------------------------------------------------------------------
// eeg_fd_queue
// Two-entry frame queue between the front and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eeg_fd_queue
  import eeg_fd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  logic    pop,
  output frame_t  head,
  output q_stat_t q_stat
);

  frame_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_pop;

  assign q_stat.empty = (count == 2'd0);
  assign q_stat.full  = (count == 2'd2);
  assign head         = entry[rd_ptr];
  assign do_pop       = pop && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry[wr_ptr] <= push.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push.valid, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/eeg_fd_back.sv =====
// ----------------------------------------------------------------------------
// eeg_fd_back
// Output register: takes frames from the queue and presents the fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eeg_fd_back
  import eeg_fd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_stat_t q_stat,
  input  frame_t  head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output frame_t  result
);

  // Load whenever the queue holds a frame and the register is free or being emptied this cycle.
  assign pop = !q_stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/eeg_fd_checker.sv =====
// ----------------------------------------------------------------------------
// eeg_fd_checker
// Port-level checks on the deframer, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module eeg_fd_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [31:0]        board_time,
  input wire logic signed [23:0] sample_0,
  input wire logic signed [23:0] sample_7
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
               out_valid && $stable(board_time) && $stable(sample_0) && $stable(sample_7),
               "result changed while stalled")

  `ASSERT_NOW(a_reset_empty, $past(rst), !out_valid, "result present after reset")

  `ASSERT_NOW(a_no_false_stall, !out_valid, in_ready, "input stalled with output empty")

  `ASSERT_NOW(a_result_origin, $rose(out_valid), $past(in_valid && in_ready, 2),
              "result without a byte transfer two cycles before")

endmodule

bind eeg_frame_deframer eeg_fd_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .board_time (board_time),
  .sample_0   (sample_0),
  .sample_7   (sample_7)
);

`default_nettype wire
